[sv/frx_pkg.sv]
// Shared types, codes and helpers for the firmware upload block receiver.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package frx_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam logic [23:0] BASE_RESET = 24'd2048;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] FAIL_MAX = 16'hFFFF;
  localparam int MAX_RESULTS = 4;

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_X = 8'h58;

  typedef enum logic [1:0] {
    KIND_STAGE  = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_REPLY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_LENGTH    = 3'd0,
    PH_BLOCK     = 3'd1,
    PH_BLOCK_CRC = 3'd2,
    PH_TAIL      = 3'd3,
    PH_IMAGE_CRC = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [8:0]  buffer_offset;
    logic [31:0] block_address;
    logic [7:0]  data;
    logic [15:0] crc_failures;
  } result_t;

  // All results caused by one request, in emission order.
  typedef struct packed {
    logic [2:0]                   count;
    result_t [MAX_RESULTS-1:0]    item;
  } batch_t;

  function automatic result_t mk_result(kind_t kind, logic [8:0] off, logic [31:0] addr,
                                        logic [7:0] data, logic [15:0] fails);
    result_t r;
    r.kind          = kind;
    r.buffer_offset = off;
    r.block_address = addr;
    r.data          = data;
    r.crc_failures  = fails;
    return r;
  endfunction

  // Bit-fed CRC-16, data bit enters at bit 0, MSB of the byte first.
  function automatic logic [15:0] crc_feed(logic [15:0] sum, logic [7:0] b);
    logic [15:0] s;
    logic        top;
    s = sum;
    for (int k = 0; k < 8; k++) begin
      top = s[15];
      s = {s[14:0], b[7-k]};
      if (top) begin
        s = s ^ CRC_POLY;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/frx_proto.sv]
// Upload protocol engine: phase machine, CRCs, counters and result batch build.
// Depends on frx_pkg.
`default_nettype none

module frx_proto #(
  parameter int BLOCK_BYTES = frx_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic [7:0]     rx_byte,
  input  wire logic [23:0]    base,
  output frx_pkg::batch_t     batch
);

  localparam int IW = $clog2(BLOCK_BYTES);
  localparam logic [31:0] BB32 = 32'(BLOCK_BYTES);
  localparam logic [IW:0] BB_IDX = (IW+1)'(BLOCK_BYTES);
  localparam logic [IW:0] LEN_BYTES = (IW+1)'(4);

  frx_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]   length_r, length_nxt;
  logic [IW-1:0] byte_index_r, byte_index_nxt;
  logic [31:0]   off_r, off_nxt;        // block number * BLOCK_BYTES
  logic [31:0]   off_nx_r, off_nx_nxt;  // off_r + BLOCK_BYTES
  logic [31:0]   remain_r, remain_nxt;  // bytes not yet in finished full blocks
  logic [15:0]   block_crc_r, block_crc_nxt;
  logic [15:0]   image_crc_r, image_crc_nxt;
  logic [7:0]    crc_low_r, crc_low_nxt;
  logic [15:0]   fails_r, fails_nxt;

  logic [IW:0]   idx_inc;
  logic [31:0]   idx32;
  logic [8:0]    buf_off;
  logic [15:0]   crc_b, crc_i, rcv;
  logic [31:0]   addr_cur, addr_nx, base32, rem_after, len_new;
  logic          blk_done, tail_done, more_blocks, rem_empty;
  logic          len_done, len_blocks, len_empty, crc_second, fail_inc;

  assign idx_inc     = {1'b0, byte_index_r} + (IW+1)'(1);
  assign idx32       = 32'(byte_index_r);
  assign buf_off     = idx32[8:0];
  assign crc_b       = frx_pkg::crc_feed(block_crc_r, rx_byte);
  assign crc_i       = frx_pkg::crc_feed(image_crc_r, rx_byte);
  assign rcv         = {rx_byte, crc_low_r};
  assign base32      = {8'd0, base};
  assign addr_cur    = base32 + off_r;
  assign addr_nx     = base32 + off_nx_r;
  assign rem_after   = remain_r - BB32;
  assign blk_done    = idx_inc >= BB_IDX;
  assign tail_done   = 32'(idx_inc) >= remain_r;
  assign more_blocks = rem_after >= BB32;
  assign rem_empty   = rem_after == 32'd0;
  assign len_done    = idx_inc >= LEN_BYTES;
  assign len_blocks  = len_new >= BB32;
  assign len_empty   = len_new == 32'd0;
  assign crc_second  = byte_index_r != '0;
  assign fail_inc    = (rcv != block_crc_r) && (fails_r != frx_pkg::FAIL_MAX);

  always_comb begin
    len_new = length_r;
    case (byte_index_r[1:0])
      2'd0:    len_new[7:0]   = length_r[7:0]   | rx_byte;
      2'd1:    len_new[15:8]  = length_r[15:8]  | rx_byte;
      2'd2:    len_new[23:16] = length_r[23:16] | rx_byte;
      default: len_new[31:24] = length_r[31:24] | rx_byte;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      frx_pkg::PH_BLOCK: begin
        if (blk_done) phase_nxt = frx_pkg::PH_BLOCK_CRC;
      end
      frx_pkg::PH_BLOCK_CRC: begin
        if (crc_second) begin
          if (more_blocks)    phase_nxt = frx_pkg::PH_BLOCK;
          else if (rem_empty) phase_nxt = frx_pkg::PH_IMAGE_CRC;
          else                phase_nxt = frx_pkg::PH_TAIL;
        end
      end
      frx_pkg::PH_TAIL: begin
        if (tail_done) phase_nxt = frx_pkg::PH_IMAGE_CRC;
      end
      frx_pkg::PH_IMAGE_CRC: begin
        if (crc_second) phase_nxt = frx_pkg::PH_LENGTH;
      end
      default: begin
        phase_nxt = frx_pkg::PH_LENGTH;
        if (len_done) begin
          if (len_blocks)     phase_nxt = frx_pkg::PH_BLOCK;
          else if (len_empty) phase_nxt = frx_pkg::PH_IMAGE_CRC;
          else                phase_nxt = frx_pkg::PH_TAIL;
        end
      end
    endcase
  end

  // Datapath updates and result batch.
  always_comb begin
    length_nxt     = length_r;
    byte_index_nxt = byte_index_r;
    off_nxt        = off_r;
    off_nx_nxt     = off_nx_r;
    remain_nxt     = remain_r;
    block_crc_nxt  = block_crc_r;
    image_crc_nxt  = image_crc_r;
    crc_low_nxt    = crc_low_r;
    fails_nxt      = fails_r;
    batch          = '0;
    case (phase_r)
      frx_pkg::PH_BLOCK: begin
        block_crc_nxt = crc_b;
        image_crc_nxt = crc_i;
        batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_STAGE, buf_off, 32'd0, rx_byte,
                                           fails_r);
        batch.count = 3'd1;
        if (blk_done) begin
          batch.item[1] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                             frx_pkg::CHAR_C, fails_r);
          batch.count = 3'd2;
          byte_index_nxt = '0;
        end else begin
          byte_index_nxt = idx_inc[IW-1:0];
        end
      end
      frx_pkg::PH_BLOCK_CRC: begin
        if (!crc_second) begin
          crc_low_nxt    = rx_byte;
          byte_index_nxt = IW'(1);
        end else begin
          if (fail_inc) fails_nxt = fails_r + 16'd1;
          batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_COMMIT, 9'd0, addr_cur, 8'd0,
                                             fails_nxt);
          batch.item[1] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                             frx_pkg::CHAR_B, fails_nxt);
          batch.count = 3'd2;
          off_nxt        = off_nx_r;
          off_nx_nxt     = off_nx_r + BB32;
          remain_nxt     = rem_after;
          block_crc_nxt  = 16'd0;
          byte_index_nxt = '0;
          // Empty tail: commit the tail block right away.
          if (!more_blocks && rem_empty) begin
            batch.item[2] = frx_pkg::mk_result(frx_pkg::KIND_COMMIT, 9'd0, addr_nx, 8'd0,
                                               fails_nxt);
            batch.item[3] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                               frx_pkg::CHAR_B, fails_nxt);
            batch.count = 3'd4;
          end
        end
      end
      frx_pkg::PH_TAIL: begin
        image_crc_nxt = crc_i;
        batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_STAGE, buf_off, 32'd0, rx_byte,
                                           fails_r);
        batch.count = 3'd1;
        if (tail_done) begin
          batch.item[1] = frx_pkg::mk_result(frx_pkg::KIND_COMMIT, 9'd0, addr_cur, 8'd0,
                                             fails_r);
          batch.item[2] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                             frx_pkg::CHAR_B, fails_r);
          batch.count = 3'd3;
          byte_index_nxt = '0;
        end else begin
          byte_index_nxt = idx_inc[IW-1:0];
        end
      end
      frx_pkg::PH_IMAGE_CRC: begin
        batch.count = 3'd1;
        if (!crc_second) begin
          crc_low_nxt    = rx_byte;
          byte_index_nxt = IW'(1);
          batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                             frx_pkg::CHAR_B, fails_r);
        end else begin
          batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                             (rcv == image_crc_r) ? frx_pkg::CHAR_Z
                                                                  : frx_pkg::CHAR_X,
                                             fails_r);
          // End of upload: clear everything but the failure count.
          length_nxt     = 32'd0;
          byte_index_nxt = '0;
          off_nxt        = 32'd0;
          off_nx_nxt     = BB32;
          remain_nxt     = 32'd0;
          block_crc_nxt  = 16'd0;
          image_crc_nxt  = 16'd0;
          crc_low_nxt    = 8'd0;
        end
      end
      default: begin
        length_nxt = len_new;
        if (len_done) begin
          byte_index_nxt = '0;
          off_nxt        = 32'd0;
          off_nx_nxt     = BB32;
          remain_nxt     = len_new;
          block_crc_nxt  = 16'd0;
          image_crc_nxt  = 16'd0;
          if (!len_blocks && len_empty) begin
            batch.item[0] = frx_pkg::mk_result(frx_pkg::KIND_COMMIT, 9'd0, base32, 8'd0,
                                               fails_r);
            batch.item[1] = frx_pkg::mk_result(frx_pkg::KIND_REPLY, 9'd0, 32'd0,
                                               frx_pkg::CHAR_B, fails_r);
            batch.count = 3'd2;
          end
        end else begin
          byte_index_nxt = idx_inc[IW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= frx_pkg::PH_LENGTH;
      length_r     <= 32'd0;
      byte_index_r <= '0;
      off_r        <= 32'd0;
      off_nx_r     <= BB32;
      remain_r     <= 32'd0;
      block_crc_r  <= 16'd0;
      image_crc_r  <= 16'd0;
      crc_low_r    <= 8'd0;
      fails_r      <= 16'd0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      length_r     <= length_nxt;
      byte_index_r <= byte_index_nxt;
      off_r        <= off_nxt;
      off_nx_r     <= off_nx_nxt;
      remain_r     <= remain_nxt;
      block_crc_r  <= block_crc_nxt;
      image_crc_r  <= image_crc_nxt;
      crc_low_r    <= crc_low_nxt;
      fails_r      <= fails_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/frx_outq.sv]
// Result buffer: holds the batch of one request and drains it one result per cycle
// while out_tready is high. Depends on frx_pkg.
`default_nettype none

module frx_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire frx_pkg::batch_t batch,
  output logic                 free,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [71:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  frx_pkg::result_t [3:0] item_r;
  frx_pkg::result_t       cur;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [1:0]             head_r, head_nxt;
  logic                   pop, at_last;

  assign cur        = item_r[head_r];
  assign at_last    = ({1'b0, head_r} + 3'd1) == cnt_r;
  assign out_tvalid = cnt_r != 3'd0;
  assign pop        = out_tvalid && out_tready;
  assign free       = !out_tvalid || (pop && at_last);
  assign out_tdata  = {7'd0, cur.crc_failures, cur.data, cur.block_address, cur.buffer_offset};
  assign out_tuser  = cur.kind;
  assign out_tlast  = at_last;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (load) begin
      cnt_nxt  = batch.count;
      head_nxt = 2'd0;
    end else if (pop) begin
      if (at_last) begin
        cnt_nxt  = 3'd0;
        head_nxt = 2'd0;
      end else begin
        head_nxt = head_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      head_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= batch.item;
    end
  end

endmodule

`default_nettype wire

[sv/firmware_upload_block_receiver_top.sv]
// Top level of the firmware upload block receiver: input register, base register,
// protocol engine and result buffer. Depends on frx_pkg, frx_proto and frx_outq.
`default_nettype none

// Receives a firmware upload one byte per request: a 4-byte little-endian image
// length, then full blocks of BLOCK_BYTES bytes each followed by a 2-byte block CRC
// (low byte first), then the tail bytes and a 2-byte image CRC. Both CRCs are the
// bit-fed CRC-16 (poly 0x1021, start 0). Each byte causes zero to four results:
// stage-byte writes (tuser 0), block commits (tuser 1, address = base + block
// number * BLOCK_BYTES) and reply characters (tuser 2: C, B, Z, X); tlast marks the
// final result of a byte. Timing: a byte is captured in the input register, then
// processed as soon as the result buffer is free or draining its final result;
// while it is free, bytes with no result (length bytes of a non-empty image, block
// CRC-low bytes) stream at one per clock. A byte with results holds the port until
// they drain (at most 4, for a block CRC then an empty tail) while the next byte
// waits in the input register. The output port is fed straight from the registered
// result buffer. The base address resets to 0x800; the user must write it via
// cfg_wr_en and cfg_wr_data only while no upload byte is in flight (not enforced).
module firmware_upload_block_receiver_top #(
  parameter int BLOCK_BYTES = frx_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Upload byte requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [8:0] buffer_offset, [40:9] block_address,
                                       // [48:41] data, [64:49] crc_failures, rest 0
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,
  // Base address register.
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data
);

  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic [23:0]     base_r;
  logic            fire, q_free;
  frx_pkg::batch_t batch;

  // Process the held byte once the result buffer can take its batch.
  assign fire      = in_valid_r && q_free;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      base_r     <= frx_pkg::BASE_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // Payload holds; only the valid flag needs reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  frx_proto #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_proto (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .base    (base_r),
    .batch   (batch)
  );

  frx_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .batch      (batch),
    .free       (q_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[sv/frx_checker.sv]
// Port-level checks for the firmware upload block receiver, with its bind.
// Depends on frx_pkg and firmware_upload_block_receiver_top.
`default_nettype none

module frx_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result changed while stalled");

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == frx_pkg::KIND_STAGE) || (out_tuser == frx_pkg::KIND_COMMIT)
                   || (out_tuser == frx_pkg::KIND_REPLY))
    else $error("unknown result kind");

  // A commit is always followed by its B reply for the same byte.
  a_commit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == frx_pkg::KIND_COMMIT) |-> !out_tlast
                  && (out_tdata[8:0] == 9'd0) && (out_tdata[48:41] == 8'd0))
    else $error("malformed commit result");

  // The image verdict ends its byte's results.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == frx_pkg::KIND_REPLY)
      && ((out_tdata[48:41] == frx_pkg::CHAR_Z) || (out_tdata[48:41] == frx_pkg::CHAR_X))
      |-> out_tlast)
    else $error("image verdict not last");

  // Failure count only rises between consecutive results.
  a_fail_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |-> out_tdata[64:49] >= $past(out_tdata[64:49]))
    else $error("failure count decreased");

endmodule

bind firmware_upload_block_receiver_top frx_checker u_frx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
